### rtl/bis_pkg.sv
// ---------------------------------------------------------------------------
// bis_pkg
// Shared sizes, codes, record types and helpers of the bilinear sampler.
// ---------------------------------------------------------------------------
package bis_pkg;

	// Store geometry and number formats
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int PIXEL_BITS = 16;
	localparam int FRAC_BITS  = 8;

	// Fixed field widths of the streams
	localparam int COORD_BITS   = 18;
	localparam int ROW_IN_BITS  = 8;
	localparam int COL_IN_BITS  = 8;
	localparam int VAL_IN_BITS  = 16;
	localparam int OUT_BITS     = 16;
	localparam int REG_BITS     = 9;
	localparam int CFG_IDX_BITS = 2;
	localparam int REG_RESET    = 256;

	// Packed stream words, padded to whole bytes
	localparam int IN_USED_BITS  = ROW_IN_BITS + COL_IN_BITS + VAL_IN_BITS + 2 * COORD_BITS;
	localparam int IN_DATA_BITS  = ((IN_USED_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;

	// Index widths
	localparam int XW = $clog2(MAX_WIDTH);
	localparam int YW = $clog2(MAX_HEIGHT);

	// Four banks split by row and column parity; each holds one quarter of the image
	localparam int HALF_W     = (MAX_WIDTH + 1) / 2;
	localparam int HALF_H     = (MAX_HEIGHT + 1) / 2;
	localparam int BANK_DEPTH = HALF_W * HALF_H;
	localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int NUM_BANKS  = 4;

	// Comparison width: holds a dimension shifted up by the fraction bits
	localparam int INT_BITS = COORD_BITS - FRAC_BITS;
	localparam int CMP_BITS = ((REG_BITS > INT_BITS) ? REG_BITS : INT_BITS) + FRAC_BITS + 1;

	// Blend widths
	localparam int WT_BITS  = FRAC_BITS + 1;
	localparam int ROW_BITS = PIXEL_BITS + FRAC_BITS;
	localparam int LO_BITS  = 2 * FRAC_BITS + 1;
	localparam int SUM_BITS = PIXEL_BITS + FRAC_BITS + 1;
	localparam int RES_BITS = PIXEL_BITS + 1;
	localparam int SAT_BITS = (RES_BITS > OUT_BITS + 1) ? RES_BITS : OUT_BITS + 1;

	localparam logic [WT_BITS-1:0] SCALE      = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [LO_BITS-1:0] ROUND_HALF = {2'b01, {(2 * FRAC_BITS - 1){1'b0}}};
	localparam logic [OUT_BITS-1:0] OUT_MAX   = '1;

	typedef enum logic {
		REQ_WRITE  = 1'b0,
		REQ_SAMPLE = 1'b1
	} req_kind_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_IMAGE_WIDTH  = CFG_IDX_BITS'(0),
		REG_IMAGE_HEIGHT = CFG_IDX_BITS'(1)
	} cfg_reg_t;

	// Decoded request, as held in stage 1
	typedef struct packed {
		logic                  is_sample;
		logic                  oor;
		logic                  wr_ok;
		logic [FRAC_BITS-1:0]  fx;
		logic [FRAC_BITS-1:0]  fy;
		logic [XW-1:0]         x1;
		logic [XW-1:0]         x2;
		logic [YW-1:0]         y1;
		logic [YW-1:0]         y2;
		logic [YW-1:0]         wr_row;
		logic [XW-1:0]         wr_col;
		logic [PIXEL_BITS-1:0] wr_val;
	} req_t;

	// The four neighbors, qCR: C column (1 = x1, 2 = x2), R row (1 = y1, 2 = y2)
	typedef struct packed {
		logic [PIXEL_BITS-1:0] q11;
		logic [PIXEL_BITS-1:0] q21;
		logic [PIXEL_BITS-1:0] q12;
		logic [PIXEL_BITS-1:0] q22;
	} quad_t;

	// Load enables of the arithmetic stages
	typedef struct packed {
		logic s3;
		logic s4;
		logic s5;
	} stage_en_t;

	// Address inside a parity bank
	function automatic logic [BANK_AW-1:0] bank_addr(input logic [YW-1:0] row,
			input logic [XW-1:0] col);
		logic [BANK_AW+YW+XW-1:0] full;
		full = (BANK_AW+YW+XW)'(row >> 1) * (BANK_AW+YW+XW)'(HALF_W)
			+ (BANK_AW+YW+XW)'(col >> 1);
		return full[BANK_AW-1:0];
	endfunction

endpackage

### rtl/bis_ram.sv
// ---------------------------------------------------------------------------
// bis_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module bis_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### rtl/bis_index.sv
// ---------------------------------------------------------------------------
// bis_index
// Request decode: range check, floor, neighbor clamp, write address check.
// ---------------------------------------------------------------------------
module bis_index import bis_pkg::*; (
	input  logic                   req_type,
	input  logic [ROW_IN_BITS-1:0] pixel_row,
	input  logic [COL_IN_BITS-1:0] pixel_col,
	input  logic [VAL_IN_BITS-1:0] pixel_value,
	input  logic [COORD_BITS-1:0]  coord_x,
	input  logic [COORD_BITS-1:0]  coord_y,
	input  logic [REG_BITS-1:0]    image_width,
	input  logic [REG_BITS-1:0]    image_height,
	output req_t                   req
);

	logic [CMP_BITS-1:0] w_eff, h_eff;
	logic [CMP_BITS-1:0] xs_u, ys_u;
	logic [CMP_BITS-1:0] x_int, y_int;
	logic                x_neg, y_neg;

	function automatic logic [CMP_BITS-1:0] clamp_idx(input logic [CMP_BITS-1:0] v,
			input logic [CMP_BITS-1:0] lim);
		logic [CMP_BITS-1:0] last;
		last = lim - CMP_BITS'(1);
		return (v > last) ? last : v;
	endfunction

	// oversized registers act as the store size
	assign w_eff = (CMP_BITS'(image_width) > CMP_BITS'(MAX_WIDTH)) ?
		CMP_BITS'(MAX_WIDTH) : CMP_BITS'(image_width);
	assign h_eff = (CMP_BITS'(image_height) > CMP_BITS'(MAX_HEIGHT)) ?
		CMP_BITS'(MAX_HEIGHT) : CMP_BITS'(image_height);

	assign x_neg = coord_x[COORD_BITS-1];
	assign y_neg = coord_y[COORD_BITS-1];
	assign xs_u  = CMP_BITS'(coord_x);
	assign ys_u  = CMP_BITS'(coord_y);
	assign x_int = xs_u >> FRAC_BITS;
	assign y_int = ys_u >> FRAC_BITS;

	always_comb begin
		req.is_sample = (req_type == REQ_SAMPLE);
		// a coordinate equal to the size is still inside
		req.oor = (w_eff == '0) || (h_eff == '0) || x_neg || y_neg
			|| (xs_u > (w_eff << FRAC_BITS)) || (ys_u > (h_eff << FRAC_BITS));
		req.fx = coord_x[FRAC_BITS-1:0];
		req.fy = coord_y[FRAC_BITS-1:0];
		req.x1 = XW'(clamp_idx(x_int, w_eff));
		req.x2 = XW'(clamp_idx(x_int + CMP_BITS'(1), w_eff));
		req.y1 = YW'(clamp_idx(y_int, h_eff));
		req.y2 = YW'(clamp_idx(y_int + CMP_BITS'(1), h_eff));
		req.wr_ok = (CMP_BITS'(pixel_row) < CMP_BITS'(MAX_HEIGHT))
			&& (CMP_BITS'(pixel_col) < CMP_BITS'(MAX_WIDTH));
		req.wr_row = YW'(pixel_row);
		req.wr_col = XW'(pixel_col);
		req.wr_val = PIXEL_BITS'(pixel_value);
	end

endmodule

### rtl/bis_store.sv
// ---------------------------------------------------------------------------
// bis_store
// Image store in four parity banks; fetches all four neighbors per cycle while rd_en is set.
// ---------------------------------------------------------------------------
module bis_store import bis_pkg::*; (
	input  logic  clk,
	input  req_t  req,
	input  logic  rd_en,
	input  logic  wr_en,
	output quad_t quad
);

	// neighbors differ by at most one in each axis, so each bank sees one read
	logic [NUM_BANKS-1:0][PIXEL_BITS-1:0] bank_q;
	logic x1p_s2, x2p_s2, y1p_s2, y2p_s2;

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam logic RP = 1'(b / 2);
		localparam logic CP = 1'(b % 2);

		logic [YW-1:0] rd_row;
		logic [XW-1:0] rd_col;
		logic          bank_we;

		assign rd_row  = (req.y1[0] == RP) ? req.y1 : req.y2;
		assign rd_col  = (req.x1[0] == CP) ? req.x1 : req.x2;
		assign bank_we = wr_en && (req.wr_row[0] == RP) && (req.wr_col[0] == CP);

		bis_ram #(
			.WIDTH(PIXEL_BITS),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (bank_we),
			.waddr(bank_addr(req.wr_row, req.wr_col)),
			.wdata(req.wr_val),
			.re   (rd_en),
			.raddr(bank_addr(rd_row, rd_col)),
			.rdata(bank_q[b])
		);
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			x1p_s2 <= req.x1[0];
			x2p_s2 <= req.x2[0];
			y1p_s2 <= req.y1[0];
			y2p_s2 <= req.y2[0];
		end
	end

	// bank index is {row parity, column parity}
	assign quad.q11 = bank_q[{y1p_s2, x1p_s2}];
	assign quad.q21 = bank_q[{y1p_s2, x2p_s2}];
	assign quad.q12 = bank_q[{y2p_s2, x1p_s2}];
	assign quad.q22 = bank_q[{y2p_s2, x2p_s2}];

endmodule

### rtl/bis_blend.sv
// ---------------------------------------------------------------------------
// bis_blend
// Three-stage blend: row blends, column blend, round and saturate.
// ---------------------------------------------------------------------------
module bis_blend import bis_pkg::*; (
	input  logic                 clk,
	input  stage_en_t            en,
	input  quad_t                quad,
	input  logic [FRAC_BITS-1:0] fx,
	input  logic [FRAC_BITS-1:0] fy,
	input  logic                 oor,
	output logic [OUT_BITS-1:0]  sample_value,
	output logic                 out_of_range
);

	logic [WT_BITS-1:0]   wx0, wy0;
	logic [ROW_BITS-1:0]  r1_c, r2_c;
	logic [ROW_BITS-1:0]  r1_s3, r2_s3;
	logic [FRAC_BITS-1:0] fy_s3;
	logic                 oor_s3;

	logic [ROW_BITS-1:0]  hi_c, hi_s4;
	logic [LO_BITS-1:0]   lo_c, lo_s4;
	logic                 oor_s4;

	logic [SUM_BITS-1:0]  sum_c;
	logic [SAT_BITS-1:0]  res_c;
	logic [OUT_BITS-1:0]  sat_c;
	logic [OUT_BITS-1:0]  sample_value_s5;
	logic                 out_of_range_s5;

	// row blends at scale S
	assign wx0  = SCALE - WT_BITS'(fx);
	assign r1_c = ROW_BITS'(wx0) * ROW_BITS'(quad.q11) + ROW_BITS'(fx) * ROW_BITS'(quad.q21);
	assign r2_c = ROW_BITS'(wx0) * ROW_BITS'(quad.q12) + ROW_BITS'(fx) * ROW_BITS'(quad.q22);

	always_ff @(posedge clk) begin
		if (en.s3) begin
			r1_s3  <= r1_c;
			r2_s3  <= r2_c;
			fy_s3  <= fy;
			oor_s3 <= oor;
		end
	end

	// column blend, split into integer and fraction parts of the row blends
	assign wy0  = SCALE - WT_BITS'(fy_s3);
	assign hi_c = ROW_BITS'(wy0) * ROW_BITS'(r1_s3[ROW_BITS-1:FRAC_BITS])
		+ ROW_BITS'(fy_s3) * ROW_BITS'(r2_s3[ROW_BITS-1:FRAC_BITS]);
	assign lo_c = LO_BITS'(wy0) * LO_BITS'(r1_s3[FRAC_BITS-1:0])
		+ LO_BITS'(fy_s3) * LO_BITS'(r2_s3[FRAC_BITS-1:0]) + ROUND_HALF;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			hi_s4  <= hi_c;
			lo_s4  <= lo_c;
			oor_s4 <= oor_s3;
		end
	end

	// single rounding at the end, half rounds up
	assign sum_c = SUM_BITS'(hi_s4) + SUM_BITS'(lo_s4 >> FRAC_BITS);
	assign res_c = SAT_BITS'(sum_c[SUM_BITS-1:FRAC_BITS]);
	assign sat_c = (res_c > SAT_BITS'(OUT_MAX)) ? OUT_MAX : OUT_BITS'(res_c);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			sample_value_s5 <= oor_s4 ? '0 : sat_c;
			out_of_range_s5 <= oor_s4;
		end
	end

	assign sample_value = sample_value_s5;
	assign out_of_range = out_of_range_s5;

endmodule

### rtl/bilinear_image_sampler.sv
// ---------------------------------------------------------------------------
// bilinear_image_sampler
// Results: a sample result is offered on m_tvalid from the output register of stage 5;
//   a pixel write is stored as it leaves stage 1 and gives no result.
// Throughput: one transaction per cycle while m_tready does not back up the pipeline, set by
//   the four parity banks that each serve one neighbor read and one write per cycle.
// Reset: clears all stage valid bits and sets the image size to 256 x 256;
//   the pixel store is not cleared and is undefined until written.
// ---------------------------------------------------------------------------
module bilinear_image_sampler import bis_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	// configuration write channel
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [REG_BITS-1:0]      cfg_data,
	// request stream
	input  logic                     s_tvalid,
	output logic                     s_tready,
	// pixel_row, pixel_col, pixel_value, coord_x, coord_y, zero pad
	input  logic [IN_DATA_BITS-1:0]  s_tdata,
	// req_type
	input  logic                     s_tuser,
	// result stream
	output logic                     m_tvalid,
	input  logic                     m_tready,
	// sample_value
	output logic [OUT_DATA_BITS-1:0] m_tdata,
	// out_of_range
	output logic                     m_tuser
);

	// Bit positions of the request fields inside s_tdata
	localparam int ROW_LSB = 0;
	localparam int COL_LSB = ROW_LSB + ROW_IN_BITS;
	localparam int VAL_LSB = COL_LSB + COL_IN_BITS;
	localparam int CX_LSB  = VAL_LSB + VAL_IN_BITS;
	localparam int CY_LSB  = CX_LSB + COORD_BITS;

	// Configuration registers
	logic [REG_BITS-1:0] image_width_q, image_height_q;

	// Stage valids and load enables
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic load1, load2, load3, load4, load5;

	// Stage payload
	req_t                 req_in, req_s1;
	logic [FRAC_BITS-1:0] fx_s2, fy_s2;
	logic                 oor_s2;
	logic                 wr_en;
	quad_t                quad;
	stage_en_t            blend_en;
	logic [OUT_BITS-1:0]  sample_value;
	logic                 out_of_range;

	// -----------------------------------------------------------------------
	// Configuration: always ready; it is to be written only while the pipeline
	// is idle (the user's duty; not enforced). Other indices are accepted and dropped.
	// -----------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= REG_BITS'(REG_RESET);
			image_height_q <= REG_BITS'(REG_RESET);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// -----------------------------------------------------------------------
	// Flow control. Each stage loads when it is empty or when the stage after
	// it loads, so bubbles close up and input is taken while a finished result
	// waits at the output. Only a completely full pipeline stalls the input.
	// -----------------------------------------------------------------------
	assign load5    = !valid_s5 || m_tready;
	assign load4    = !valid_s4 || load5;
	assign load3    = !valid_s3 || load4;
	assign load2    = !valid_s2 || load3;
	assign load1    = !valid_s1 || load2;
	assign s_tready = load1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (load1) valid_s1 <= s_tvalid;
			// a pixel write leaves the pipeline once it reaches the store
			if (load2) valid_s2 <= valid_s1 && req_s1.is_sample;
			if (load3) valid_s3 <= valid_s2;
			if (load4) valid_s4 <= valid_s3;
			if (load5) valid_s5 <= valid_s4;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 1: decode the request and register it
	// -----------------------------------------------------------------------
	bis_index u_index (
		.req_type    (s_tuser),
		.pixel_row   (s_tdata[COL_LSB-1:ROW_LSB]),
		.pixel_col   (s_tdata[VAL_LSB-1:COL_LSB]),
		.pixel_value (s_tdata[CX_LSB-1:VAL_LSB]),
		.coord_x     (s_tdata[CY_LSB-1:CX_LSB]),
		.coord_y     (s_tdata[CY_LSB+COORD_BITS-1:CY_LSB]),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.req         (req_in)
	);

	always_ff @(posedge clk) begin
		if (load1) begin
			req_s1 <= req_in;
		end
	end

	// -----------------------------------------------------------------------
	// Stage 2: store access. Writes and reads both happen as the transaction
	// leaves stage 1, so a sample always sees every earlier write.
	// -----------------------------------------------------------------------
	assign wr_en = load2 && valid_s1 && !req_s1.is_sample && req_s1.wr_ok;

	bis_store u_store (
		.clk  (clk),
		.req  (req_s1),
		.rd_en(load2),
		.wr_en(wr_en),
		.quad (quad)
	);

	always_ff @(posedge clk) begin
		if (load2) begin
			fx_s2  <= req_s1.fx;
			fy_s2  <= req_s1.fy;
			oor_s2 <= req_s1.oor;
		end
	end

	// -----------------------------------------------------------------------
	// Stages 3 to 5: weighting, rounding and the output register
	// -----------------------------------------------------------------------
	assign blend_en.s3 = load3;
	assign blend_en.s4 = load4;
	assign blend_en.s5 = load5;

	bis_blend u_blend (
		.clk         (clk),
		.en          (blend_en),
		.quad        (quad),
		.fx          (fx_s2),
		.fy          (fy_s2),
		.oor         (oor_s2),
		.sample_value(sample_value),
		.out_of_range(out_of_range)
	);

	assign m_tvalid = valid_s5;
	assign m_tdata  = OUT_DATA_BITS'(sample_value);
	assign m_tuser  = out_of_range;

	// -----------------------------------------------------------------------
	// Assertions
	// -----------------------------------------------------------------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5))
		else $error("input stalled while a pipeline stage was empty");

	a_sample_reaches_s2: assert property (@(posedge clk) disable iff (!arst_n)
		(load2 && valid_s1 && req_s1.is_sample) |=> valid_s2)
		else $error("sample transaction lost between stage 1 and stage 2");

	a_write_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		(load2 && valid_s1 && !req_s1.is_sample) |=> !valid_s2)
		else $error("pixel write carried past the store");

	a_oor_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata == '0))
		else $error("out of range result with nonzero value");

endmodule
